// ----- hdl/mhpf_pkg.sv -----
// Package for the multi-hit pulse finder: widths, register indexes and reset values.
// No dependencies; imported by every other file of the block.
`default_nettype none
package mhpf_pkg;

    localparam int MAX_SAMPLES = 4096;
    localparam int SAMPLE_BITS = 14;
    localparam int IDX_W       = $clog2(MAX_SAMPLES + 1);
    localparam int TIME_W      = 12;
    localparam int THR_W       = 15;
    localparam int RUN_W       = 4;
    localparam int PROM_W      = 14;
    localparam int SPACE_W     = 12;
    localparam int WSTART_W    = 12;
    localparam int WEND_W      = 13;
    localparam int CFG_DATA_W  = 15;
    localparam int CFG_IDX_W   = 3;

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [IDX_W-1:0]       t_index;
    typedef logic [TIME_W-1:0]      t_time;
    typedef logic [RUN_W-1:0]       t_count;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD    = 3'd0,
        REG_RUN_LENGTH   = 3'd1,
        REG_PROMINENCE   = 3'd2,
        REG_MIN_SPACING  = 3'd3,
        REG_WINDOW_START = 3'd4,
        REG_WINDOW_END   = 3'd5
    } t_cfg_reg;

    localparam logic [THR_W-1:0]    THRESHOLD_RST    = THR_W'(8192);
    localparam logic [RUN_W-1:0]    RUN_LENGTH_RST   = RUN_W'(3);
    localparam logic [PROM_W-1:0]   PROMINENCE_RST   = PROM_W'(8);
    localparam logic [SPACE_W-1:0]  MIN_SPACING_RST  = SPACE_W'(4);
    localparam logic [WSTART_W-1:0] WINDOW_START_RST = WSTART_W'(0);
    localparam logic [WEND_W-1:0]   WINDOW_END_RST   = WEND_W'(4096);

    localparam t_count COUNT_MAX = {RUN_W{1'b1}};
    localparam t_index INDEX_MAX = IDX_W'(MAX_SAMPLES);

endpackage
`default_nettype wire

// ----- hdl/mhpf_in_if.sv -----
// Sample channel of the pulse finder: valid/ready plus sample payload.
// Depends on mhpf_pkg.
`default_nettype none
interface mhpf_in_if
    import mhpf_pkg::*;
;
    logic    valid;
    logic    ready;
    t_sample sample;
    logic    first_sample;

    modport source (output valid, output sample, output first_sample, input ready);
    modport sink   (input valid, input sample, input first_sample, output ready);
endinterface
`default_nettype wire

// ----- hdl/mhpf_out_if.sv -----
// Hit channel of the pulse finder: valid/ready plus hit time payload.
// Depends on mhpf_pkg.
`default_nettype none
interface mhpf_out_if
    import mhpf_pkg::*;
;
    logic  valid;
    logic  ready;
    t_time hit_time;

    modport source (output valid, output hit_time, input ready);
    modport sink   (input valid, input hit_time, output ready);
endinterface
`default_nettype wire

// ----- hdl/multi_hit_pulse_finder.sv -----
// A sample is held in the input register; a hit from it is then registered in the output register.
// Throughput: one sample per cycle while no pending hit stalls the output; the state
// update is a few compares between the input register and the result register.
// A pending hit on a stalled output holds the input stage, hit or not.
// Synchronous active-low reset clears the pipeline and waveform state.
// Depends on mhpf_pkg, mhpf_in_if and mhpf_out_if.
`default_nettype none
module multi_hit_pulse_finder
    import mhpf_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_DATA_W-1:0] i_cfg_wdata,
    mhpf_in_if.sink              i_in,
    mhpf_out_if.source           o_out
);

    // configuration
    logic [THR_W-1:0]    r_threshold;
    logic [RUN_W-1:0]    r_run_length;
    logic [PROM_W-1:0]   r_prominence;
    logic [SPACE_W-1:0]  r_min_spacing;
    logic [WSTART_W-1:0] r_window_start;
    logic [WEND_W-1:0]   r_window_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold    <= THRESHOLD_RST;
            r_run_length   <= RUN_LENGTH_RST;
            r_prominence   <= PROMINENCE_RST;
            r_min_spacing  <= MIN_SPACING_RST;
            r_window_start <= WINDOW_START_RST;
            r_window_end   <= WINDOW_END_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_THRESHOLD:    r_threshold    <= i_cfg_wdata[THR_W-1:0];
                REG_RUN_LENGTH:   r_run_length   <= i_cfg_wdata[RUN_W-1:0];
                REG_PROMINENCE:   r_prominence   <= i_cfg_wdata[PROM_W-1:0];
                REG_MIN_SPACING:  r_min_spacing  <= i_cfg_wdata[SPACE_W-1:0];
                REG_WINDOW_START: r_window_start <= i_cfg_wdata[WSTART_W-1:0];
                REG_WINDOW_END:   r_window_end   <= i_cfg_wdata[WEND_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    logic    r_in_valid;
    t_sample r_sample;
    logic    r_first;
    logic    advance;

    assign advance    = r_in_valid && (!o_out.valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_sample <= i_in.sample;
            r_first  <= i_in.first_sample;
        end
    end

    // waveform state
    t_index  r_idx,       n_idx;
    logic    r_in_pulse,  n_in_pulse;
    t_count  r_below,     n_below;
    t_time   r_run_start, n_run_start;
    t_sample r_high,      n_high;
    t_time   r_last_hit,  n_last_hit;
    logic    r_out_valid;
    t_time   r_out_hit;
    logic    emit;
    t_time   hit;

    t_index  cur_idx;
    logic    cur_pulse;
    t_count  cur_below;
    t_count  inc_below;
    t_time   cur_run_start;
    t_sample cur_high;
    t_sample new_high;
    t_time   cur_last_hit;
    logic    in_window;
    logic    is_below;
    t_sample drop;
    t_index  since_hit;

    always_comb begin
        // a new waveform sees cleared state at index zero
        cur_idx       = r_first ? '0 : r_idx;
        cur_pulse     = r_first ? 1'b0 : r_in_pulse;
        cur_below     = r_first ? '0 : r_below;
        cur_run_start = r_first ? '0 : r_run_start;
        cur_high      = r_first ? '0 : r_high;
        cur_last_hit  = r_first ? '0 : r_last_hit;

        n_idx       = (cur_idx < INDEX_MAX) ? cur_idx + IDX_W'(1) : cur_idx;
        n_in_pulse  = cur_pulse;
        n_below     = cur_below;
        n_run_start = cur_run_start;
        n_high      = cur_high;
        n_last_hit  = cur_last_hit;
        emit        = 1'b0;
        hit         = cur_idx[TIME_W-1:0];

        in_window = (IDX_W'(r_window_start) <= cur_idx)
                 && (IDX_W'(cur_idx) < IDX_W'(r_window_end))
                 && (cur_idx < INDEX_MAX);
        is_below  = THR_W'(r_sample) < r_threshold;
        inc_below = (cur_below < COUNT_MAX) ? cur_below + RUN_W'(1) : cur_below;
        new_high  = (r_sample > cur_high) ? r_sample : cur_high;
        drop      = new_high - r_sample;
        since_hit = cur_idx - IDX_W'(cur_last_hit);

        if (in_window) begin
            if (is_below) begin
                if (!cur_pulse) begin
                    if (cur_below == '0) begin
                        n_run_start = cur_idx[TIME_W-1:0];
                    end
                    n_below = inc_below;
                    if (inc_below >= r_run_length) begin
                        n_in_pulse = 1'b1;
                        emit       = 1'b1;
                        hit        = n_run_start;
                        n_high     = r_sample;
                        n_last_hit = cur_idx[TIME_W-1:0];
                    end
                end else begin
                    n_high = new_high;
                    if (PROM_W'(drop) > r_prominence
                        && cur_idx >= IDX_W'(cur_last_hit)
                        && since_hit >= IDX_W'(r_min_spacing)) begin
                        emit       = 1'b1;
                        hit        = cur_idx[TIME_W-1:0];
                        n_high     = r_sample;
                        n_last_hit = cur_idx[TIME_W-1:0];
                    end
                end
            end else begin
                n_in_pulse = 1'b0;
                n_below    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_in_pulse  <= 1'b0;
            r_below     <= '0;
            r_run_start <= '0;
            r_high      <= '0;
            r_last_hit  <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_idx       <= n_idx;
            r_in_pulse  <= n_in_pulse;
            r_below     <= n_below;
            r_run_start <= n_run_start;
            r_high      <= n_high;
            r_last_hit  <= n_last_hit;
            r_out_valid <= emit;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out_hit <= hit;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.hit_time = r_out_hit;

    // an accepted pulse always has a nonzero run count
    a_pulse_has_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_pulse |-> r_below != '0)
        else $error("in pulse with empty run count");

    a_idx_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= INDEX_MAX)
        else $error("sample index past saturation");

    // a new waveform restarts the index at zero, so the next one is one
    a_first_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_first |=> r_idx == IDX_W'(1))
        else $error("first sample did not restart the index");

    // a stalled hit blocks the input stage
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |-> !advance)
        else $error("input stage advanced over a pending hit");

endmodule
`default_nettype wire

// ----- test/multi_hit_pulse_finder_tb.sv -----
// Self-checking testbench for multi_hit_pulse_finder: a local model predicts every hit time,
// and each hit transfer is checked against it under random idling and back-pressure.
// Depends on mhpf_pkg, mhpf_in_if, mhpf_out_if and the multi_hit_pulse_finder RTL.
module multi_hit_pulse_finder_tb;
    import mhpf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_ITEMS   = 1450;
    localparam int HOLD_CYCLES  = 150;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int MAX_REPORTS  = 40;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    mhpf_in_if  smp_if ();
    mhpf_out_if hit_if ();

    multi_hit_pulse_finder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (smp_if),
        .o_out       (hit_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Register copies, updated as each write goes out
    logic [THR_W-1:0]    thr_cfg      = THRESHOLD_RST;
    logic [RUN_W-1:0]    need_run_cfg = RUN_LENGTH_RST;
    logic [PROM_W-1:0]   drop_cfg     = PROMINENCE_RST;
    logic [SPACE_W-1:0]  spacing_cfg  = MIN_SPACING_RST;
    logic [WSTART_W-1:0] win_lo_cfg   = WINDOW_START_RST;
    logic [WEND_W-1:0]   win_hi_cfg   = WINDOW_END_RST;

    // Waveform tracking state of the local model
    t_index  next_idx     = '0;
    logic    pulse_active = 1'b0;
    t_count  below_run    = '0;
    t_time   run_origin   = '0;
    t_sample peak_level   = '0;
    t_time   prev_hit     = '0;

    t_time pending_hits[$];

    int  err_count     = 0;
    int  cycle_count   = 0;
    bit  src_idle_en   = 1'b0;
    bit  sink_stall_en = 1'b0;
    bit  hold_req      = 1'b0;
    int  stall_left    = 0;

    function automatic void queue_hit(t_time h);
        pending_hits = {pending_hits, h};
    endfunction

    function automatic void track_sample(t_sample s, logic first);
        t_index idx;
        if (first) begin
            next_idx     = '0;
            pulse_active = 1'b0;
            below_run    = '0;
            run_origin   = '0;
            peak_level   = '0;
            prev_hit     = '0;
        end
        idx = next_idx;
        if (next_idx < INDEX_MAX)
            next_idx = next_idx + 1'b1;
        if (idx < win_lo_cfg || idx >= win_hi_cfg || idx >= INDEX_MAX)
            return;
        if (s < thr_cfg) begin
            if (!pulse_active) begin
                if (below_run == 0)
                    run_origin = idx[TIME_W-1:0];
                if (below_run < COUNT_MAX)
                    below_run = below_run + 1'b1;
                if (below_run >= need_run_cfg) begin
                    pulse_active = 1'b1;
                    queue_hit(run_origin);
                    peak_level = s;
                    prev_hit   = idx[TIME_W-1:0];
                end
            end else begin
                if (s > peak_level)
                    peak_level = s;
                if (peak_level - s > drop_cfg && idx >= prev_hit
                        && idx - prev_hit >= spacing_cfg) begin
                    queue_hit(idx[TIME_W-1:0]);
                    peak_level = s;
                    prev_hit   = idx[TIME_W-1:0];
                end
            end
        end else begin
            pulse_active = 1'b0;
            below_run    = '0;
        end
    endfunction

    // Check the hit first so a hit cannot match a sample taken on the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (hit_if.valid && hit_if.ready) begin
                if (pending_hits.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: unexpected hit, expected none, got hit_time %0d",
                                 $time, hit_if.hit_time);
                end else begin
                    t_time want;
                    want = pending_hits.pop_front();
                    if (hit_if.hit_time !== want) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS)
                            $display("%0t: hit_time mismatch, expected %0d, got %0d",
                                     $time, want, hit_if.hit_time);
                    end
                end
            end
            if (smp_if.valid && smp_if.ready)
                track_sample(smp_if.sample, smp_if.first_sample);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d hits outstanding", $time, pending_hits.size());
            $display("multi_hit_pulse_finder test failed");
            $finish;
        end
    end

    // Hit receiver: one ready decision per falling edge
    initial begin
        hit_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                hit_if.ready <= 1'b0;
                stall_left--;
            end else if (hold_req) begin
                hold_req     = 1'b0;
                stall_left   = HOLD_CYCLES - 1;
                hit_if.ready <= 1'b0;
            end else if (sink_stall_en && $urandom_range(0, 7) == 0) begin
                stall_left   = $urandom_range(0, 8);
                hit_if.ready <= 1'b0;
            end else begin
                hit_if.ready <= 1'b1;
            end
        end
    end

    task automatic send_sample(t_sample s, logic first);
        int gap;
        @(negedge i_clk);
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            smp_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        smp_if.valid        <= 1'b1;
        smp_if.sample       <= s;
        smp_if.first_sample <= first;
        do @(posedge i_clk); while (!smp_if.ready);
    endtask

    // Drop valid, wait for every hit, then give the pipeline time with ready high
    task automatic wait_idle();
        int n;
        n = 0;
        @(negedge i_clk);
        smp_if.valid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge i_clk);
        while (n < 8) begin
            @(posedge i_clk);
            if (hit_if.ready)
                n++;
        end
    endtask

    task automatic write_reg(t_cfg_reg r, logic [CFG_DATA_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= r;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (r)
            REG_THRESHOLD:    thr_cfg      = v[THR_W-1:0];
            REG_RUN_LENGTH:   need_run_cfg = v[RUN_W-1:0];
            REG_PROMINENCE:   drop_cfg     = v[PROM_W-1:0];
            REG_MIN_SPACING:  spacing_cfg  = v[SPACE_W-1:0];
            REG_WINDOW_START: win_lo_cfg   = v[WSTART_W-1:0];
            REG_WINDOW_END:   win_hi_cfg   = v[WEND_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all(int thr, int run, int prom, int spacing, int lo, int hi);
        write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
        write_reg(REG_RUN_LENGTH, CFG_DATA_W'(run));
        write_reg(REG_PROMINENCE, CFG_DATA_W'(prom));
        write_reg(REG_MIN_SPACING, CFG_DATA_W'(spacing));
        write_reg(REG_WINDOW_START, CFG_DATA_W'(lo));
        write_reg(REG_WINDOW_END, CFG_DATA_W'(hi));
    endtask

    // Baseline above threshold with random dips below it; the dips carry sub-peaks
    task automatic send_waveform(int len, bit marked);
        int pulse_left;
        int lvl;
        int span;
        pulse_left = 0;
        span = int'(drop_cfg) * 2 + 30;
        for (int i = 0; i < len; i++) begin
            if (pulse_left == 0 && $urandom_range(0, 7) == 0)
                pulse_left = $urandom_range(2, 30);
            if (pulse_left > 0) begin
                lvl = int'(thr_cfg) - 1 - int'($urandom_range(0, span));
                pulse_left--;
            end else begin
                lvl = int'(thr_cfg) + int'($urandom_range(0, 40));
            end
            if (lvl < 0)
                lvl = 0;
            if (lvl > 16383)
                lvl = 16383;
            send_sample(t_sample'(lvl), marked && i == 0);
            if (src_idle_en && $urandom_range(0, 150) == 0)
                wait_idle();
        end
    endtask

    task automatic randomize_config();
        int thr, run, prom, spacing, lo, hi;
        case ($urandom_range(0, 9))
            0:       thr = 16384;
            1:       thr = 0;
            2:       thr = $urandom_range(0, 32767);
            default: thr = $urandom_range(500, 16000);
        endcase
        run = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
        case ($urandom_range(0, 9))
            0:       prom = 16383;
            1:       prom = 0;
            2:       prom = $urandom_range(0, 16383);
            default: prom = $urandom_range(0, 300);
        endcase
        case ($urandom_range(0, 9))
            0:       spacing = 4095;
            1:       spacing = 0;
            2:       spacing = $urandom_range(0, 4095);
            default: spacing = $urandom_range(0, 12);
        endcase
        lo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 20);
        case ($urandom_range(0, 9))
            0:       hi = $urandom_range(0, 8191);
            1:       hi = $urandom_range(20, 150);
            default: hi = 4096;
        endcase
        write_all(thr, run, prom, spacing, lo, hi);
    endtask

    // Reset settings: pulse start, blocked and allowed sub-hits, short broken run
    task automatic test_basic_pulse();
        send_sample(14'd9000, 1'b1);
        send_sample(14'd8000, 1'b0);
        send_sample(14'd7000, 1'b0);
        send_sample(14'd6000, 1'b0);
        send_sample(14'd6500, 1'b0);
        send_sample(14'd6400, 1'b0);
        send_sample(14'd6490, 1'b0);
        send_sample(14'd6300, 1'b0);
        send_sample(14'd9000, 1'b0);
        send_sample(14'd0, 1'b0);
        send_sample(14'd16383, 1'b0);
        wait_idle();
    endtask

    task automatic test_special_cases();
        // every sample below, instant accept, any drop is a hit
        write_all(16384, 0, 0, 0, 0, 4096);
        send_sample(14'd16383, 1'b1);
        send_sample(14'd16383, 1'b0);
        send_sample(14'd0, 1'b0);
        send_sample(14'd0, 1'b1);
        wait_idle();
        // nothing is below a zero threshold
        write_reg(REG_THRESHOLD, CFG_DATA_W'(0));
        send_sample(14'd0, 1'b0);
        wait_idle();
        // widest prominence and spacing block every sub-hit
        write_all(8192, 1, 16383, 4095, 0, 4096);
        send_sample(14'd100, 1'b1);
        send_sample(14'd8191, 1'b0);
        send_sample(14'd0, 1'b0);
        wait_idle();
        // window end before window start: nothing examined
        write_all(16384, 0, 0, 0, 6, 2);
        send_sample(14'd0, 1'b1);
        send_sample(14'd0, 1'b0);
        send_sample(14'd0, 1'b0);
        wait_idle();
    endtask

    // Late window whose end lies past the index range, under random receiver stalls
    task automatic test_long_waveform();
        write_all(16384, 0, 0, 0, 250, 8191);
        sink_stall_en = 1'b1;
        send_sample(t_sample'($urandom_range(0, 16383)), 1'b1);
        repeat (299)
            send_sample(t_sample'($urandom_range(0, 16383)), 1'b0);
        wait_idle();
        sink_stall_en = 1'b0;
    endtask

    // Long receiver hold-off while samples keep coming
    task automatic test_backpressure();
        write_all(8192, 2, 8, 2, 0, 4096);
        @(posedge i_clk);
        hold_req = 1'b1;
        send_waveform(60, 1'b1);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int sent;
        int phase_end;
        int len;
        bit quiet;
        sent = 0;
        while (sent < RAND_ITEMS) begin
            quiet = (sent >= RAND_ITEMS - 250);
            wait_idle();
            src_idle_en   = !quiet && $urandom_range(0, 3) != 0;
            sink_stall_en = !quiet && $urandom_range(0, 3) != 0;
            randomize_config();
            phase_end = sent + $urandom_range(100, 200);
            while (sent < phase_end && sent < RAND_ITEMS) begin
                if ($urandom_range(0, 4) == 0) begin
                    len = $urandom_range(1, 10);
                    repeat (len)
                        send_sample(t_sample'($urandom_range(0, 16383)),
                                    $urandom_range(0, 3) == 0);
                end else begin
                    len = $urandom_range(20, 120);
                    send_waveform(len, $urandom_range(0, 7) != 0);
                end
                sent += len;
            end
        end
    endtask

    initial begin
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = REG_THRESHOLD;
        i_cfg_wdata         = '0;
        smp_if.valid        = 1'b0;
        smp_if.sample       = '0;
        smp_if.first_sample = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_pulse();
        test_special_cases();
        test_long_waveform();
        test_backpressure();
        test_random_traffic();
        wait_idle();

        if (err_count == 0)
            $display("multi_hit_pulse_finder test passed");
        else
            $display("multi_hit_pulse_finder test failed");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/mhpf_pkg.sv
hdl/mhpf_in_if.sv
hdl/mhpf_out_if.sv
hdl/multi_hit_pulse_finder.sv
test/multi_hit_pulse_finder_tb.sv
